>>> rtl/core/hofus_pkg.sv
// Shared types and constants for the Hall/observer angle and speed fusion block.
`default_nettype none

package hofus_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int SPEED_BITS       = 24;
    localparam int WEIGHT_FRAC_BITS = 16;

    localparam int MIN_SPEED_W = SPEED_BITS - 1;
    localparam int MAX_ERR_W   = ANGLE_BITS;
    localparam int WEIGHT_W    = WEIGHT_FRAC_BITS + 1;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [MIN_SPEED_W-1:0] MIN_SPEED_RST = MIN_SPEED_W'(2560);
    localparam logic [MAX_ERR_W-1:0]   MAX_ERR_RST   = MAX_ERR_W'(10923);
    localparam logic [WEIGHT_W-1:0]    WEIGHT_RST    = WEIGHT_W'(6554);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_SPEED       = 8'd0,
        REG_MAX_ANGLE_ERROR = 8'd1,
        REG_ANGLE_WEIGHT    = 8'd2,
        REG_SPEED_WEIGHT    = 8'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_FIRST     = 2'd0,
        MODE_LOW_SPEED = 2'd1,
        MODE_DIVERGED  = 2'd2,
        MODE_BLENDED   = 2'd3
    } fusion_mode_t;

    typedef struct packed {
        logic        [ANGLE_BITS-1:0] obs_angle;
        logic signed [SPEED_BITS-1:0] obs_speed;
        logic        [ANGLE_BITS-1:0] hall_angle;
        logic signed [SPEED_BITS-1:0] hall_vel;
    } in_item_t;

    typedef struct packed {
        logic        [ANGLE_BITS-1:0] fused_angle;
        logic signed [SPEED_BITS-1:0] fused_vel;
        logic        [1:0]            fusion_mode;
    } out_item_t;

    typedef struct packed {
        logic [MIN_SPEED_W-1:0] min_speed;
        logic [MAX_ERR_W-1:0]   max_angle_error;
        logic [WEIGHT_W-1:0]    angle_weight;
        logic [WEIGHT_W-1:0]    speed_weight;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/hofus_cfg.sv
// Configuration register file for the fusion block.
`default_nettype none

module hofus_cfg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [hofus_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [hofus_pkg::CFG_DATA_W-1:0]   cfg_data,
    output      hofus_pkg::cfg_t                    cfg
);
    import hofus_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg         = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_speed       <= MIN_SPEED_RST;
            cfg_reg.max_angle_error <= MAX_ERR_RST;
            cfg_reg.angle_weight    <= WEIGHT_RST;
            cfg_reg.speed_weight    <= WEIGHT_RST;
        end else if (cfg_valid) begin
            // unknown indexes drop silently
            case (cfg_index)
                REG_MIN_SPEED:       cfg_reg.min_speed       <= cfg_data[MIN_SPEED_W-1:0];
                REG_MAX_ANGLE_ERROR: cfg_reg.max_angle_error <= cfg_data[MAX_ERR_W-1:0];
                REG_ANGLE_WEIGHT:    cfg_reg.angle_weight    <= cfg_data[WEIGHT_W-1:0];
                REG_SPEED_WEIGHT:    cfg_reg.speed_weight    <= cfg_data[WEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hofus_calc.sv
// Single-pass fusion datapath: mode decision, angle correction and speed blend.
`default_nettype none

module hofus_calc (
    input  wire hofus_pkg::in_item_t  item,
    input  wire hofus_pkg::cfg_t      cfg,
    input  wire logic                 started,
    output      hofus_pkg::out_item_t result
);
    import hofus_pkg::*;

    localparam int ERR_W   = ANGLE_BITS + 2;
    localparam int APROD_W = ERR_W + WEIGHT_W + 1;
    localparam int SDIF_W  = SPEED_BITS + 1;
    localparam int SPROD_W = SDIF_W + WEIGHT_W + 1;
    localparam int DS_W    = SPROD_W - WEIGHT_FRAC_BITS;
    localparam int FS_W    = DS_W + 1;

    localparam logic signed [ERR_W-1:0] HALF = ERR_W'(1) <<< (ANGLE_BITS - 1);
    localparam logic signed [ERR_W-1:0] FULL = ERR_W'(1) <<< ANGLE_BITS;

    logic        [SPEED_BITS-1:0] speed_mag;
    logic signed [ERR_W-1:0]      err_raw;
    logic signed [ERR_W-1:0]      err;
    logic        [ERR_W-1:0]      err_mag;
    logic signed [APROD_W-1:0]    aprod;
    logic signed [APROD_W-1:0]    corr;
    logic signed [SDIF_W-1:0]     sdif;
    logic signed [SPROD_W-1:0]    sprod;
    logic signed [DS_W-1:0]       ds;
    logic signed [FS_W-1:0]       fs_wide;
    logic signed [SPEED_BITS-1:0] fs_sat;
    logic                         fs_ovf;

    always_comb begin
        // magnitude fits unsigned even for the most negative speed
        speed_mag = item.obs_speed[SPEED_BITS-1] ? SPEED_BITS'(-item.obs_speed)
                                                 : SPEED_BITS'(item.obs_speed);

        err_raw = $signed(ERR_W'(item.hall_angle)) - $signed(ERR_W'(item.obs_angle));
        // fold only strictly beyond half a turn
        if (err_raw > HALF) begin
            err = err_raw - FULL;
        end else if (err_raw < -HALF) begin
            err = err_raw + FULL;
        end else begin
            err = err_raw;
        end
        err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

        aprod = $signed(APROD_W'(err)) * $signed(APROD_W'({1'b0, cfg.angle_weight}));
        corr  = aprod >>> WEIGHT_FRAC_BITS;

        sdif  = $signed(SDIF_W'(item.hall_vel)) - $signed(SDIF_W'(item.obs_speed));
        sprod = $signed(SPROD_W'(sdif)) * $signed(SPROD_W'({1'b0, cfg.speed_weight}));
        ds    = DS_W'(sprod >>> WEIGHT_FRAC_BITS);

        fs_wide = $signed(FS_W'(item.obs_speed)) + $signed(FS_W'(ds));
        fs_ovf  = (fs_wide[FS_W-1:SPEED_BITS-1] != {(FS_W-SPEED_BITS+1){1'b0}})
               && (fs_wide[FS_W-1:SPEED_BITS-1] != {(FS_W-SPEED_BITS+1){1'b1}});
        if (fs_ovf) begin
            fs_sat = fs_wide[FS_W-1] ? {1'b1, {(SPEED_BITS-1){1'b0}}}
                                     : {1'b0, {(SPEED_BITS-1){1'b1}}};
        end else begin
            fs_sat = fs_wide[SPEED_BITS-1:0];
        end

        if (!started) begin
            result.fused_angle = item.hall_angle;
            result.fused_vel   = item.hall_vel;
            result.fusion_mode = MODE_FIRST;
        end else if (speed_mag < SPEED_BITS'(cfg.min_speed)) begin
            result.fused_angle = item.obs_angle;
            result.fused_vel   = item.obs_speed;
            result.fusion_mode = MODE_LOW_SPEED;
        end else if (err_mag > ERR_W'(cfg.max_angle_error)) begin
            result.fused_angle = item.hall_angle;
            result.fused_vel   = item.hall_vel;
            result.fusion_mode = MODE_DIVERGED;
        end else begin
            result.fused_angle = item.obs_angle + corr[ANGLE_BITS-1:0];
            result.fused_vel   = fs_sat;
            result.fusion_mode = MODE_BLENDED;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hall_observer_angle_speed_fusion_top.sv
// Top level of the Hall/observer angle and speed fusion block.
`default_nettype none

// Fuses an observer angle/speed pair with a Hall-sensor pair, one result beat per
// input beat. Throughput is one beat per clock while m_ready holds: the angle and speed
// multipliers sit in one combinational pass between the input register and the result
// register. A beat moves from the input register into the result register when that
// register is free or draining. While a result waits, the input register still takes
// one more beat; later beats stall until the result drains. The first beat after reset
// returns the Hall values. Registers are written through the cfg channel (index 0
// min_speed, 1 max_angle_error, 2 angle_weight, 3 speed_weight); write them only while
// no beat is in flight.
module hall_observer_angle_speed_fusion_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output      logic                              s_ready,
    input  wire hofus_pkg::in_item_t               s_data,
    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      hofus_pkg::out_item_t              m_data,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [hofus_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hofus_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hofus_pkg::*;

    cfg_t      cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    logic      started_reg;
    out_item_t calc_result;
    logic      advance;

    hofus_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hofus_calc u_calc (
        .item    (in_data_reg),
        .cfg     (cfg),
        .started (started_reg),
        .result  (calc_result)
    );

    // move the held beat into the result register when it is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                started_reg   <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= calc_result;
        end
    end

endmodule

`default_nettype wire

>>> sim/tb_hall_observer_angle_speed_fusion_top.sv
// Self-checking testbench for the Hall/observer angle and speed fusion block.
module tb_hall_observer_angle_speed_fusion_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hofus_pkg::*;

    localparam int     LIMIT_CYCLES    = 300000;
    localparam int     DRAIN_CYCLES    = 4;
    localparam int     MAX_REPORTS     = 10;
    localparam int     BLOCK_ITEMS     = 280;
    localparam int     FIRST_SPARE_REG = 4;
    localparam int     LAST_REG_INDEX  = (1 << CFG_INDEX_W) - 1;
    localparam int     SPEED_MAX       = (1 << (SPEED_BITS - 1)) - 1;
    localparam int     SPEED_MIN       = -SPEED_MAX - 1;
    localparam int     HALF_TURN       = 1 << (ANGLE_BITS - 1);
    localparam int     FULL_TURN       = 1 << ANGLE_BITS;
    localparam int     MIN_SPEED_MAX   = (1 << MIN_SPEED_W) - 1;
    localparam int     MAX_ERR_MAX     = (1 << MAX_ERR_W) - 1;
    localparam int     WEIGHT_ONE      = 1 << WEIGHT_FRAC_BITS;
    localparam int     WEIGHT_MAX      = (1 << WEIGHT_W) - 1;

    class fusion_scoreboard;
        logic [MIN_SPEED_W-1:0] min_speed;
        logic [MAX_ERR_W-1:0]   max_err;
        logic [WEIGHT_W-1:0]    angle_w;
        logic [WEIGHT_W-1:0]    speed_w;
        bit                     started;
        out_item_t              fused_due[$];
        int unsigned            accepted;
        int unsigned            checked;
        int unsigned            mismatches;
        int unsigned            mode_seen[4];

        function new();
            min_speed  = MIN_SPEED_RST;
            max_err    = MAX_ERR_RST;
            angle_w    = WEIGHT_RST;
            speed_w    = WEIGHT_RST;
            started    = 1'b0;
            accepted   = 0;
            checked    = 0;
            mismatches = 0;
            foreach (mode_seen[i]) mode_seen[i] = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_MIN_SPEED:       min_speed = d[MIN_SPEED_W-1:0];
                REG_MAX_ANGLE_ERROR: max_err   = d[MAX_ERR_W-1:0];
                REG_ANGLE_WEIGHT:    angle_w   = d[WEIGHT_W-1:0];
                REG_SPEED_WEIGHT:    speed_w   = d[WEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        function out_item_t fuse(in_item_t it);
            out_item_t r;
            longint    os, hs, mag, err, emag, corr, ds, fs;
            os  = $signed(it.obs_speed);
            hs  = $signed(it.hall_vel);
            mag = (os < 0) ? -os : os;
            err = longint'(it.hall_angle) - longint'(it.obs_angle);
            // fold only strictly beyond half a turn
            if (err > HALF_TURN) err -= FULL_TURN;
            else if (err < -HALF_TURN) err += FULL_TURN;
            emag = (err < 0) ? -err : err;
            if (!started) begin
                started       = 1'b1;
                r.fused_angle = it.hall_angle;
                r.fused_vel   = it.hall_vel;
                r.fusion_mode = MODE_FIRST;
            end else if (mag < longint'(min_speed)) begin
                r.fused_angle = it.obs_angle;
                r.fused_vel   = it.obs_speed;
                r.fusion_mode = MODE_LOW_SPEED;
            end else if (emag > longint'(max_err)) begin
                r.fused_angle = it.hall_angle;
                r.fused_vel   = it.hall_vel;
                r.fusion_mode = MODE_DIVERGED;
            end else begin
                corr = (err * longint'(angle_w)) >>> WEIGHT_FRAC_BITS;
                ds   = ((hs - os) * longint'(speed_w)) >>> WEIGHT_FRAC_BITS;
                fs   = os + ds;
                if (fs > SPEED_MAX) fs = SPEED_MAX;
                if (fs < SPEED_MIN) fs = SPEED_MIN;
                r.fused_angle = ANGLE_BITS'(longint'(it.obs_angle) + corr);
                r.fused_vel   = SPEED_BITS'(fs);
                r.fusion_mode = MODE_BLENDED;
            end
            return r;
        endfunction

        function void note_input(in_item_t it);
            out_item_t want;
            want = fuse(it);
            fused_due.push_back(want);
            accepted++;
            mode_seen[want.fusion_mode]++;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (fused_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: angle %0d speed %0d mode %0d",
                             got.fused_angle, got.fused_vel, got.fusion_mode);
                return;
            end
            want = fused_due.pop_front();
            checked++;
            if (got.fused_angle !== want.fused_angle ||
                got.fused_vel   !== want.fused_vel ||
                got.fusion_mode !== want.fusion_mode) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: want %0d/%0d/%0d, got %0d/%0d/%0d",
                             checked, want.fused_angle, want.fused_vel, want.fusion_mode,
                             got.fused_angle, got.fused_vel, got.fusion_mode);
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    fusion_scoreboard sb = new();
    int unsigned      send_idle = 36;
    int unsigned      recv_idle = 87;
    int unsigned      cycles    = 0;
    int unsigned      settings  = 1;

    hall_observer_angle_speed_fusion_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) m_ready = ($urandom_range(99) >= recv_idle);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycles, sb.fused_due.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic in_item_t mk(int unsigned oa, int os, int unsigned ha, int hs);
        in_item_t it;
        it.obs_angle  = ANGLE_BITS'(oa);
        it.obs_speed  = SPEED_BITS'(os);
        it.hall_angle = ANGLE_BITS'(ha);
        it.hall_vel   = SPEED_BITS'(hs);
        return it;
    endfunction

    // Mostly tracking pairs, some near the thresholds; the rest low speed or raw noise.
    function automatic in_item_t rand_item();
        in_item_t    it;
        int unsigned pick;
        longint      lim, mag, os, hs, d;
        pick          = $urandom_range(99);
        it.obs_angle  = ANGLE_BITS'($urandom);
        it.obs_speed  = SPEED_BITS'($urandom);
        it.hall_angle = ANGLE_BITS'($urandom);
        it.hall_vel   = SPEED_BITS'($urandom);
        lim = (longint'(sb.max_err) > HALF_TURN) ? HALF_TURN : longint'(sb.max_err);
        if (pick < 15) begin
            return it;
        end else if (pick < 25) begin
            mag = $urandom_range(sb.min_speed);
            os  = $urandom_range(1) ? -mag : mag;
            it.obs_speed = SPEED_BITS'(os);
        end else begin
            if (pick < 40) begin
                mag = longint'(sb.min_speed) + $urandom_range(2) - 1;
                if (mag < 0) mag = 0;
                case ($urandom_range(3))
                    0:       d = lim + $urandom_range(1);
                    1:       d = -lim - $urandom_range(1);
                    2:       d = $urandom_range(1) ? HALF_TURN : -HALF_TURN;
                    default: d = longint'($urandom_range(2 * lim + 4)) - lim - 2;
                endcase
            end else begin
                mag = $urandom_range(1) ? $urandom_range(SPEED_MAX, sb.min_speed)
                                        : longint'(sb.min_speed) + $urandom_range(4095);
                d   = longint'($urandom_range(2 * lim + 4)) - lim - 2;
            end
            if (mag > SPEED_MAX) mag = SPEED_MAX;
            os = $urandom_range(1) ? -mag : mag;
            if ($urandom_range(63) == 0) os = SPEED_MIN;
            hs = os + longint'($urandom_range(1 << $urandom_range(23))) *
                      ($urandom_range(1) ? -1 : 1);
            if (hs > SPEED_MAX) hs = SPEED_MAX;
            if (hs < SPEED_MIN) hs = SPEED_MIN;
            it.obs_speed  = SPEED_BITS'(os);
            it.hall_vel   = SPEED_BITS'(hs);
            it.hall_angle = ANGLE_BITS'(longint'(it.obs_angle) + d);
        end
        return it;
    endfunction

    // Call at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(it);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        while (sb.fused_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, d);
        @(negedge aclk);
    endtask

    // Junk above each register width, then one write to an unused index.
    task automatic program_regs(input int unsigned ms, me, aw, sw);
        write_reg(REG_MIN_SPEED,       ($urandom << MIN_SPEED_W) | ms);
        write_reg(REG_MAX_ANGLE_ERROR, ($urandom << MAX_ERR_W) | me);
        write_reg(REG_ANGLE_WEIGHT,    ($urandom << WEIGHT_W) | aw);
        write_reg(REG_SPEED_WEIGHT,    ($urandom << WEIGHT_W) | sw);
        write_reg(CFG_INDEX_W'($urandom_range(LAST_REG_INDEX, FIRST_SPARE_REG)), $urandom);
        cfg_valid = 1'b0;
        settings++;
    endtask

    task automatic settle();
        s_valid = 1'b0;
        wait_idle();
    endtask

    task automatic run_block(input int n);
        int pause_at;
        pause_at = $urandom_range(n - 1, n / 4);
        for (int k = 0; k < n; k++) begin
            // hold off until the pipeline has fully drained
            if (k == pause_at) settle();
            send_item(rand_item());
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // first beat, speed threshold edges, wrap, half turn, error limit edges
        send_item(mk(0, 0, MAX_ERR_MAX, SPEED_MIN));
        send_item(mk(MAX_ERR_MAX, 0, 0, SPEED_MAX));
        send_item(mk(100, 2559, 200, 0));
        send_item(mk(100, 2560, 200, 3000));
        send_item(mk(100, -2559, 200, 0));
        send_item(mk(100, -2560, 50, -5000));
        send_item(mk(65500, 100000, 40, 90000));
        send_item(mk(40, -100000, 65500, -120000));
        send_item(mk(0, 50000, HALF_TURN, 60000));
        send_item(mk(HALF_TURN, 50000, 0, 60000));
        send_item(mk(1000, 50000, 11923, 40000));
        send_item(mk(1000, 50000, 11924, 40000));
        send_item(mk(20000, 50000, 9077, 40000));
        send_item(mk(0, SPEED_MIN, 0, SPEED_MAX));
        send_item(mk(MAX_ERR_MAX, SPEED_MAX, 0, SPEED_MIN));
        settle();

        // weights above one drive the speed into saturation
        program_regs(MIN_SPEED_MAX, MAX_ERR_MAX, WEIGHT_MAX, WEIGHT_MAX);
        send_item(mk(0, SPEED_MIN, HALF_TURN, SPEED_MAX));
        send_item(mk(HALF_TURN, SPEED_MAX, 0, SPEED_MIN));
        send_item(mk(1, SPEED_MAX - 1, 2, 0));
        send_item(mk(1, -SPEED_MAX, 2, 0));
        settle();

        program_regs(0, 0, WEIGHT_ONE, WEIGHT_ONE);
        send_item(mk(12345, 0, 12345, 777));
        send_item(mk(12345, 0, 12346, 777));
        send_item(mk(MAX_ERR_MAX, -1, MAX_ERR_MAX, SPEED_MIN));
        settle();

        program_regs(0, HALF_TURN, 0, 0);
        send_item(mk(5000, 300000, 6000, -300000));
        settle();

        for (int b = 0; b < 6; b++) begin
            case (b)
                0: program_regs(MIN_SPEED_RST, MAX_ERR_RST, WEIGHT_RST, WEIGHT_RST);
                1: program_regs(0, HALF_TURN, WEIGHT_ONE, WEIGHT_ONE);
                2: program_regs($urandom_range(20000), $urandom_range(HALF_TURN),
                                $urandom_range(WEIGHT_ONE), $urandom_range(WEIGHT_ONE));
                3: program_regs(MIN_SPEED_MAX, 0, 0, 0);
                4: program_regs($urandom_range(4000), $urandom_range(HALF_TURN, 1000),
                                $urandom_range(WEIGHT_MAX, WEIGHT_ONE + 1),
                                $urandom_range(WEIGHT_MAX, WEIGHT_ONE + 1));
                default: program_regs($urandom_range(MIN_SPEED_MAX),
                                      $urandom_range(MAX_ERR_MAX),
                                      $urandom_range(WEIGHT_MAX), $urandom_range(WEIGHT_MAX));
            endcase
            case (b / 2)
                0:       begin send_idle = 36; recv_idle = 87; end
                1:       begin send_idle = 87; recv_idle = 36; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            run_block(BLOCK_ITEMS);
            settle();
        end

        $display("Run covered %0d input beats under %0d register settings, %0d checked",
                 sb.accepted, settings, sb.checked);
        $display("Modes seen: first %0d, low speed %0d, diverged %0d, blended %0d",
                 sb.mode_seen[MODE_FIRST], sb.mode_seen[MODE_LOW_SPEED],
                 sb.mode_seen[MODE_DIVERGED], sb.mode_seen[MODE_BLENDED]);
        if (sb.mismatches == 0 && sb.fused_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/hofus_pkg.sv
rtl/core/hofus_cfg.sv
rtl/core/hofus_calc.sv
rtl/core/hall_observer_angle_speed_fusion_top.sv
sim/tb_hall_observer_angle_speed_fusion_top.sv
